>>> design/lpm_pkg.sv
// shared types, constants and helpers for the longest prefix match router core
// no dependencies
package lpm_pkg;

   localparam int ADDR_W   = 32;
   localparam int LEN_W    = 6;
   localparam int IFACE_W  = 4;
   localparam int TTL_W    = 8;
   localparam int STATUS_W = 3;

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

   typedef enum logic [0:0] {
      OP_ADD   = 1'b0,
      OP_ROUTE = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_FORWARDED   = 3'd0,
      ST_NO_ROUTE    = 3'd1,
      ST_TTL_EXPIRED = 3'd2,
      ST_ADDED       = 3'd3,
      ST_FULL        = 3'd4
   } status_type;

   // per-route data read once the winner is known
   typedef struct packed {
      logic               has_next_hop;
      logic [ADDR_W-1:0]  gateway;
      logic [IFACE_W-1:0] iface;
   } route_data_type;

   // word fields that ride alongside the lookup
   typedef struct packed {
      op_type            op;
      status_type        add_status;
      logic [ADDR_W-1:0] dest;
      logic [TTL_W-1:0]  ttl;
   } side_type;

   function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
      return (len > MAX_LEN) ? MAX_LEN : len;
   endfunction

   // high len bits set, zero length gives an empty mask
   function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
      return ~({ADDR_W{1'b1}} >> len);
   endfunction

endpackage

>>> design/lpm_table.sv
// route storage with one prefix compare cell per entry and a registered data read
// depends on lpm_pkg
module lpm_table #(
   parameter int  TABLE_DEPTH = 32,
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [lpm_pkg::ADDR_W-1:0]   wr_prefix,
   input  logic [lpm_pkg::LEN_W-1:0]    wr_len,
   input  lpm_pkg::route_data_type      wr_data,
   input  logic [lpm_pkg::ADDR_W-1:0]   look_addr,
   output logic [TABLE_DEPTH-1:0]       hit,
   output logic [lpm_pkg::LEN_W-1:0]    hit_len [TABLE_DEPTH],
   output logic                         full,
   input  logic                         rd_en,
   input  logic [IDX_W-1:0]             rd_idx,
   output lpm_pkg::route_data_type      rd_data
);
   import lpm_pkg::*;

   logic [ADDR_W-1:0] prefix_mem [TABLE_DEPTH];
   logic [ADDR_W-1:0] mask_mem   [TABLE_DEPTH];
   logic [LEN_W-1:0]  len_mem    [TABLE_DEPTH];
   route_data_type    data_mem   [TABLE_DEPTH];
   logic [CNT_W-1:0]  count_ff;
   route_data_type    rd_data_ff;

   assign full    = (count_ff == CNT_W'(TABLE_DEPTH));
   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (wr_en) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   // routes fill slots in arrival order and are never overwritten
   always_ff @(posedge clock) begin
      if (wr_en) begin
         prefix_mem[count_ff[IDX_W-1:0]] <= wr_prefix;
         len_mem[count_ff[IDX_W-1:0]]    <= sat_len(wr_len);
         mask_mem[count_ff[IDX_W-1:0]]   <= prefix_mask(sat_len(wr_len));
         data_mem[count_ff[IDX_W-1:0]]   <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= data_mem[rd_idx];
      end
   end

   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         hit[i]     = (CNT_W'(i) < count_ff) &&
                      (((prefix_mem[i] ^ look_addr) & mask_mem[i]) == '0);
         hit_len[i] = len_mem[i];
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("route count above table depth");

   a_no_write_full: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !full)
      else $error("write into a full table");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> count_ff == CNT_W'($past(count_ff) + 1'b1))
      else $error("route count did not advance on a write");

endmodule

>>> design/lpm_select.sv
// registered reduction tree picking the longest hit, earliest slot on a tie
// depends on lpm_pkg
module lpm_select #(
   parameter int  TABLE_DEPTH = 32,
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic [TABLE_DEPTH-1:0]    hit,
   input  logic [lpm_pkg::LEN_W-1:0] hit_len [TABLE_DEPTH],
   output logic                      win_hit,
   output logic [IDX_W-1:0]          win_idx
);
   import lpm_pkg::*;

   localparam int LVL    = $clog2(TABLE_DEPTH);
   localparam int LEAF_N = 1 << LVL;
   localparam int NODE_N = 2 * LEAF_N - 1;

   typedef struct packed {
      logic             hit;
      logic [LEN_W-1:0] len;
      logic [IDX_W-1:0] idx;
   } node_type;

   node_type leaf_in [LEAF_N];
   node_type node_ff [NODE_N];

   // left child always holds the lower slots, so it keeps ties
   function automatic node_type pick(input node_type l, input node_type r);
      return (r.hit && (!l.hit || (r.len > l.len))) ? r : l;
   endfunction

   for (genvar g = 0; g < LEAF_N; g++) begin : g_leaf
      if (g < TABLE_DEPTH) begin : g_real
         assign leaf_in[g] = '{hit: hit[g], len: hit_len[g], idx: IDX_W'(g)};
      end else begin : g_pad
         assign leaf_in[g] = '{hit: 1'b0, len: '0, idx: IDX_W'(g)};
      end
   end

   // heap layout: root at 0, leaves at the top, one tree level per stage
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < LEAF_N; i++) begin
            node_ff[LEAF_N - 1 + i] <= leaf_in[i];
         end
         for (int j = 0; j < LEAF_N - 1; j++) begin
            node_ff[j] <= pick(node_ff[2 * j + 1], node_ff[2 * j + 2]);
         end
      end
   end

   assign win_hit = node_ff[0].hit;
   assign win_idx = node_ff[0].idx;

endmodule

>>> design/longest_prefix_match_router_core.sv
// top level of the ipv4 longest prefix match router core
// depends on lpm_pkg, lpm_table and lpm_select
//
// The core takes one word per clock and returns one result word per input word, in
// order. An add word stores a route in the next free slot and answers route added, or
// table full once TABLE_DEPTH routes are held. A route word is compared against every
// stored route at once, one compare cell per slot, and the winner is found by a binary
// tree with a register on every level. A word passes the input register, the compare
// cells, the tree leaf register, the tree levels, the route data read and the output
// register. The whole pipeline moves on one enable, so rsp_stall holds every stage
// while an output word is valid and shows up on req_stall in the same cycle; nothing
// else ever stalls the input. An add becomes visible to the very next word, and a
// route word never sees routes added after it.
module longest_prefix_match_router_core #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_operation,
   input  logic [lpm_pkg::ADDR_W-1:0]   req_route_prefix,
   input  logic [lpm_pkg::LEN_W-1:0]    req_prefix_length,
   input  logic                         req_has_next_hop,
   input  logic [lpm_pkg::ADDR_W-1:0]   req_gateway_addr,
   input  logic [lpm_pkg::IFACE_W-1:0]  req_iface_index,
   input  logic [lpm_pkg::ADDR_W-1:0]   req_dest_addr,
   input  logic [lpm_pkg::TTL_W-1:0]    req_ttl_in,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [lpm_pkg::STATUS_W-1:0] rsp_status,
   output logic [lpm_pkg::IFACE_W-1:0]  rsp_out_iface,
   output logic [lpm_pkg::ADDR_W-1:0]   rsp_hop_addr,
   output logic [lpm_pkg::TTL_W-1:0]    rsp_ttl_out
);
   import lpm_pkg::*;

   localparam int LVL    = $clog2(TABLE_DEPTH);
   localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   // input register, tree leaves, tree levels, data read
   localparam int SIDE_N = LVL + 3;

   // pipeline control
   logic pipe_en;
   logic req_accept;
   logic table_full;
   logic wr_en;
   op_type req_op;

   // sideband that travels with each word
   side_type          side_in;
   side_type          side_ff [SIDE_N];
   logic [SIDE_N-1:0] side_vld_ff;
   side_type          tail;

   // lookup datapath
   logic [TABLE_DEPTH-1:0] hit;
   logic [LEN_W-1:0]       hit_len [TABLE_DEPTH];
   logic                   win_hit;
   logic [IDX_W-1:0]       win_idx;
   logic                   hit_ff;
   route_data_type         rd_data;
   route_data_type         wr_data;

   // result word
   status_type         status_in;
   logic [IFACE_W-1:0] iface_in;
   logic [ADDR_W-1:0]  hop_in;
   logic [TTL_W-1:0]   ttl_in;
   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [IFACE_W-1:0] rsp_out_iface_ff;
   logic [ADDR_W-1:0]  rsp_hop_addr_ff;
   logic [TTL_W-1:0]   rsp_ttl_out_ff;

   // one enable for every stage: advance unless the output word is held
   assign pipe_en    = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !pipe_en;
   assign req_accept = req_valid && pipe_en;
   assign req_op     = op_type'(req_operation);

   // table writes happen as the add word is taken, unless the table is full
   assign wr_en   = req_accept && (req_op == OP_ADD) && !table_full;
   assign wr_data = '{has_next_hop: req_has_next_hop,
                      gateway:      req_gateway_addr,
                      iface:        req_iface_index};

   // add status is settled at the input since the count is known there
   assign side_in = '{op:         req_op,
                      add_status: table_full ? ST_FULL : ST_ADDED,
                      dest:       req_dest_addr,
                      ttl:        req_ttl_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         side_vld_ff <= '0;
      end else if (pipe_en) begin
         side_vld_ff <= {side_vld_ff[SIDE_N-2:0], req_accept};
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         side_ff[0] <= side_in;
         for (int k = 1; k < SIDE_N; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // compare cells look at the registered destination
   lpm_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (wr_en),
      .wr_prefix (req_route_prefix),
      .wr_len    (req_prefix_length),
      .wr_data   (wr_data),
      .look_addr (side_ff[0].dest),
      .hit       (hit),
      .hit_len   (hit_len),
      .full      (table_full),
      .rd_en     (pipe_en),
      .rd_idx    (win_idx),
      .rd_data   (rd_data)
   );

   lpm_select #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_select (
      .clock   (clock),
      .en      (pipe_en),
      .hit     (hit),
      .hit_len (hit_len),
      .win_hit (win_hit),
      .win_idx (win_idx)
   );

   // hit flag lines up with the route data read
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         hit_ff <= win_hit;
      end
   end

   assign tail = side_ff[SIDE_N-1];

   // no route is checked before ttl, non-forwarded words carry zeros
   always_comb begin
      status_in = ST_NO_ROUTE;
      iface_in  = '0;
      hop_in    = '0;
      ttl_in    = '0;
      case (tail.op)
         OP_ADD: begin
            status_in = tail.add_status;
         end
         OP_ROUTE: begin
            if (!hit_ff) begin
               status_in = ST_NO_ROUTE;
            end else if (tail.ttl <= TTL_W'(1)) begin
               status_in = ST_TTL_EXPIRED;
            end else begin
               status_in = ST_FORWARDED;
               iface_in  = rd_data.iface;
               hop_in    = rd_data.has_next_hop ? rd_data.gateway : tail.dest;
               ttl_in    = tail.ttl - TTL_W'(1);
            end
         end
         default: begin
            status_in = ST_NO_ROUTE;
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= side_vld_ff[SIDE_N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rsp_status_ff    <= status_in;
         rsp_out_iface_ff <= iface_in;
         rsp_hop_addr_ff  <= hop_in;
         rsp_ttl_out_ff   <= ttl_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_iface = rsp_out_iface_ff;
   assign rsp_hop_addr  = rsp_hop_addr_ff;
   assign rsp_ttl_out   = rsp_ttl_out_ff;

   // a forwarded word always had ttl of two or more
   a_fwd_ttl: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_FORWARDED)) |-> (rsp_ttl_out_ff != '0))
      else $error("forwarded word with zero ttl");

   // only forwarded words carry route fields
   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != ST_FORWARDED)) |->
         ((rsp_out_iface_ff == '0) && (rsp_hop_addr_ff == '0) && (rsp_ttl_out_ff == '0)))
      else $error("non-forwarded word with route fields set");

   // add words never report lookup outcomes
   a_add_status: assert property (@(posedge clock) disable iff (reset)
      (side_vld_ff[SIDE_N-1] && (tail.op == OP_ADD)) |->
         ((status_in == ST_ADDED) || (status_in == ST_FULL)))
      else $error("add word with a lookup status");

endmodule
